@@ sv/plc_pkg.sv @@
`timescale 1ns / 1ps

package plc_pkg;

	localparam int unsigned PinLenDefault = 4;
	localparam int unsigned SaltBytes     = 4;

	localparam logic [31:0] FnvBasis = 32'h811C_9DC5;
	localparam logic [31:0] FnvPrime = 32'h0100_0193;

	localparam logic [7:0]  MaxAttemptsRst = 8'd5;
	localparam logic [31:0] BackoffRst     = 32'd60;
	localparam logic [31:0] RelockRst      = 32'd300;

	typedef enum logic [2:0] {
		CMD_DIGIT       = 3'd0,
		CMD_BEGIN       = 3'd1,
		CMD_CANCEL      = 3'd2,
		CMD_TICK        = 3'd3,
		CMD_LOCK_NOW    = 3'd4,
		CMD_LOCKOUT_ON  = 3'd5,
		CMD_LOCKOUT_OFF = 3'd6,
		CMD_UNKNOWN     = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		OUT_IDLE     = 3'd0,
		OUT_PENDING  = 3'd1,
		OUT_ACCEPTED = 3'd2,
		OUT_REJECTED = 3'd3,
		OUT_BACKOFF  = 3'd4,
		OUT_DONE     = 3'd5,
		OUT_REFUSED  = 3'd6
	} outcome_t;

	typedef enum logic [1:0] {
		MODE_UNLOCKED  = 2'd0,
		MODE_USER      = 2'd1,
		MODE_INSTALLER = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		KIND_NONE      = 2'd0,
		KIND_SCREEN    = 2'd1,
		KIND_INSTALLER = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		CFG_MAX_ATTEMPTS   = 3'd0,
		CFG_BACKOFF_SEC    = 3'd1,
		CFG_RELOCK_SEC     = 3'd2,
		CFG_USER_SALT      = 3'd3,
		CFG_USER_HASH      = 3'd4,
		CFG_INSTALLER_SALT = 3'd5,
		CFG_INSTALLER_HASH = 3'd6,
		CFG_PINS_PRESENT   = 3'd7
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_HSTART,
		ST_HWAIT,
		ST_CHECK,
		ST_EMIT
	} state_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [3:0]  key_digit;
		logic        entry_purpose;
		logic [31:0] now_seconds;
	} in_t;

	typedef struct packed {
		outcome_t    outcome;
		mode_t       screen_lock;
		logic        installer_granted;
		logic [7:0]  tries_remaining;
		logic [3:0]  digits_entered;
		logic        in_backoff;
	} out_t;

endpackage

@@ sv/plc_fnv.sv @@
`timescale 1ns / 1ps

module plc_fnv #(
	parameter int unsigned PIN_LEN = plc_pkg::PinLenDefault
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [31:0]             salt,
	input  logic [PIN_LEN-1:0][3:0] digits,
	output logic                    done,
	output logic [31:0]             hash
);
	import plc_pkg::*;

	localparam int unsigned NSteps = SaltBytes + PIN_LEN;
	localparam int unsigned CntW   = $clog2(NSteps + 1);

	// byte queue, consumed from entry 0: salt LSB first, then the digits
	logic [NSteps-1:0][7:0] seq_q;
	logic [NSteps-1:0][7:0] seq_load;
	logic [31:0]            h_q;
	logic [CntW-1:0]        cnt_q;
	logic                   done_q;
	logic [31:0]            mix;
	logic [31:0]            prod;

	always_comb begin
		for (int i = 0; i < SaltBytes; i++) begin
			seq_load[i] = salt[8*i +: 8];
		end
		for (int j = 0; j < PIN_LEN; j++) begin
			seq_load[SaltBytes + j] = {4'b0000, digits[j]};
		end
	end

	// one FNV-1a round per cycle, low 32 bits of the product
	assign mix  = h_q ^ {24'b0, seq_q[0]};
	assign prod = mix * FnvPrime;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CntW'(NSteps);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			seq_q <= seq_load;
			h_q   <= FnvBasis;
		end else if (cnt_q != '0) begin
			seq_q <= seq_q >> 8;
			h_q   <= prod;
		end
	end

	assign done = done_q;
	assign hash = h_q;

endmodule

@@ sv/pin_entry_lock_controller.sv @@
// Keypad PIN lock controller.
//
// Input channel (in_valid/in_ready/in_data): one keypad or timer event per
// transfer, each carrying the current time in seconds. Output channel
// (out_valid/out_ready/out_data): exactly one result per event, showing the
// outcome and the lock state after that event.
// Configuration: cfg_we writes cfg_wdata into the register chosen by
// cfg_index in the same cycle; write only while no event is in flight.
//
// Most events pass from the event latch through EXEC and EMIT to the output
// register; a new event is taken only once the last one is done. A digit
// that completes a PIN runs two FNV-1a hashes (user, installer) of
// PIN_LEN+4 rounds each through one shared 32x32 multiply-by-prime, one
// round a cycle, then CHECK and EMIT. in_ready is high only while idle.
// A result waits in the output register while out_ready is low; the block
// then holds the next result and takes no further event until it drains.
// Reset (arst_n low) loads the register defaults, unlocks the screen,
// clears the entry, backoff and installer flags and empties the output.
`timescale 1ns / 1ps

module pin_entry_lock_controller #(
	parameter int unsigned PIN_LEN = plc_pkg::PinLenDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  plc_pkg::in_t       in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output plc_pkg::out_t      out_data,
	input  logic               cfg_we,
	input  plc_pkg::cfg_idx_t  cfg_index,
	input  logic [31:0]        cfg_wdata
);
	import plc_pkg::*;

	localparam int unsigned IdxW      = $clog2(PIN_LEN);
	localparam logic [3:0]  PinLenCnt = 4'(PIN_LEN);

	// configuration registers
	logic [7:0]  max_att_q;
	logic [31:0] backoff_s_q;
	logic [31:0] relock_s_q;
	logic [31:0] usalt_q;
	logic [31:0] uhash_q;
	logic [31:0] isalt_q;
	logic [31:0] ihash_q;
	logic [1:0]  pins_q;

	// controller state
	state_t                  state_q, state_d;
	mode_t                   mode_q;
	kind_t                   kind_q;
	logic                    lockout_q;
	logic                    access_q;
	logic [PIN_LEN-1:0][3:0] digit_store_q;
	logic [3:0]              count_q;
	logic [7:0]              tries_q;
	logic                    boff_on_q;
	logic [31:0]             boff_until_q;
	logic [31:0]             last_act_q;

	// per-event working registers
	in_t      req_q;
	outcome_t res_q;
	logic     pass_q;
	logic     user_ok_q;
	logic     inst_ok_q;
	out_t     out_q;
	logic     out_valid_q;

	// hash unit hookup
	logic        hash_start;
	logic        hash_done;
	logic [31:0] hash_val;
	logic [31:0] hash_salt;

	// decode of the latched event
	logic        boff_act;
	logic        digit_take;
	logic        need_hash;
	logic        relock_due;
	logic [31:0] elapsed;
	logic        pin_ok;
	logic [7:0]  tries_dec;
	logic        emit_fire;

	assign boff_act   = boff_on_q && (req_q.now_seconds < boff_until_q);
	// digit is stored: entry open, not backed off, a real decimal key
	assign digit_take = (req_q.cmd == CMD_DIGIT) && (kind_q != KIND_NONE) && !boff_act
	                    && (req_q.key_digit <= 4'd9);
	assign need_hash  = digit_take && ((count_q + 4'd1) == PinLenCnt);

	// time running backwards counts as no elapsed time
	assign elapsed    = req_q.now_seconds - last_act_q;
	assign relock_due = (req_q.now_seconds >= last_act_q) ? (elapsed >= relock_s_q)
	                                                      : (relock_s_q == '0);

	// installer entry or installer lock: installer PIN only
	assign pin_ok    = ((kind_q == KIND_INSTALLER) || (mode_q == MODE_INSTALLER))
	                   ? inst_ok_q : (user_ok_q || inst_ok_q);
	assign tries_dec = (tries_q != '0) ? (tries_q - 8'd1) : 8'd0;

	assign hash_salt = pass_q ? isalt_q : usalt_q;
	assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	plc_fnv #(
		.PIN_LEN (PIN_LEN)
	) u_fnv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.salt   (hash_salt),
		.digits (digit_store_q),
		.done   (hash_done),
		.hash   (hash_val)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		hash_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = need_hash ? ST_HSTART : ST_EMIT;
			end
			ST_HSTART: begin
				hash_start = 1'b1;
				state_d    = ST_HWAIT;
			end
			ST_HWAIT: begin
				if (hash_done) begin
					state_d = pass_q ? ST_CHECK : ST_HSTART;
				end
			end
			ST_CHECK: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_fire) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// config and lock state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_att_q     <= MaxAttemptsRst;
			backoff_s_q   <= BackoffRst;
			relock_s_q    <= RelockRst;
			usalt_q       <= '0;
			uhash_q       <= '0;
			isalt_q       <= '0;
			ihash_q       <= '0;
			pins_q        <= '0;
			mode_q        <= MODE_UNLOCKED;
			kind_q        <= KIND_NONE;
			lockout_q     <= 1'b0;
			access_q      <= 1'b0;
			digit_store_q <= '0;
			count_q       <= '0;
			tries_q       <= MaxAttemptsRst;
			boff_on_q     <= 1'b0;
			boff_until_q  <= '0;
			last_act_q    <= '0;
			res_q         <= OUT_DONE;
			pass_q        <= 1'b0;
			user_ok_q     <= 1'b0;
			inst_ok_q     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MAX_ATTEMPTS: begin
						// zero is stored as one
						max_att_q <= (cfg_wdata[7:0] == '0) ? 8'd1 : cfg_wdata[7:0];
					end
					CFG_BACKOFF_SEC:    backoff_s_q <= cfg_wdata;
					CFG_RELOCK_SEC:     relock_s_q  <= cfg_wdata;
					CFG_USER_SALT:      usalt_q     <= cfg_wdata;
					CFG_USER_HASH:      uhash_q     <= cfg_wdata;
					CFG_INSTALLER_SALT: isalt_q     <= cfg_wdata;
					CFG_INSTALLER_HASH: ihash_q     <= cfg_wdata;
					CFG_PINS_PRESENT:   pins_q      <= cfg_wdata[1:0];
					default: ;
				endcase
			end

			unique case (state_q)
				ST_EXEC: begin
					res_q <= OUT_DONE;
					unique case (req_q.cmd)
						CMD_DIGIT: begin
							last_act_q <= req_q.now_seconds;
							pass_q     <= 1'b0;
							if (kind_q == KIND_NONE) begin
								res_q <= OUT_IDLE;
							end else if (boff_act) begin
								res_q <= OUT_BACKOFF;
							end else begin
								res_q <= OUT_PENDING;
							end
							if (digit_take) begin
								digit_store_q[count_q[IdxW-1:0]] <= req_q.key_digit;
								count_q <= count_q + 4'd1;
							end
						end
						CMD_BEGIN: begin
							digit_store_q <= '0;
							count_q       <= '0;
							kind_q        <= req_q.entry_purpose ? KIND_INSTALLER
							                                     : KIND_SCREEN;
							last_act_q    <= req_q.now_seconds;
						end
						CMD_CANCEL: begin
							digit_store_q <= '0;
							count_q       <= '0;
							kind_q        <= KIND_NONE;
						end
						CMD_TICK: begin
							if (boff_on_q && !boff_act) begin
								boff_on_q <= 1'b0;
								tries_q   <= max_att_q;
							end
							if (relock_due) begin
								access_q      <= 1'b0;
								digit_store_q <= '0;
								count_q       <= '0;
								kind_q        <= KIND_NONE;
								// relock only from unlocked
								if (mode_q == MODE_UNLOCKED) begin
									if (lockout_q) begin
										mode_q <= MODE_INSTALLER;
									end else if (pins_q[0]) begin
										mode_q <= MODE_USER;
									end
								end
							end
						end
						CMD_LOCK_NOW: begin
							if (!pins_q[0] || (mode_q == MODE_INSTALLER)) begin
								res_q <= OUT_REFUSED;
							end else begin
								mode_q        <= MODE_USER;
								digit_store_q <= '0;
								count_q       <= '0;
								kind_q        <= KIND_NONE;
								last_act_q    <= req_q.now_seconds;
							end
						end
						CMD_LOCKOUT_ON: begin
							if (!pins_q[1]) begin
								res_q <= OUT_REFUSED;
							end else begin
								lockout_q     <= 1'b1;
								mode_q        <= MODE_INSTALLER;
								access_q      <= 1'b0;
								digit_store_q <= '0;
								count_q       <= '0;
								kind_q        <= KIND_NONE;
								last_act_q    <= req_q.now_seconds;
							end
						end
						CMD_LOCKOUT_OFF: begin
							lockout_q <= 1'b0;
							if (mode_q == MODE_INSTALLER) begin
								mode_q <= MODE_UNLOCKED;
							end
							digit_store_q <= '0;
							count_q       <= '0;
							kind_q        <= KIND_NONE;
							last_act_q    <= req_q.now_seconds;
						end
						CMD_UNKNOWN: begin
							res_q <= OUT_REFUSED;
						end
						default: ;
					endcase
				end
				ST_HWAIT: begin
					if (hash_done) begin
						if (!pass_q) begin
							user_ok_q <= pins_q[0] && (hash_val == uhash_q);
							pass_q    <= 1'b1;
						end else begin
							inst_ok_q <= pins_q[1] && (hash_val == ihash_q);
						end
					end
				end
				ST_CHECK: begin
					digit_store_q <= '0;
					count_q       <= '0;
					kind_q        <= KIND_NONE;
					if (pin_ok) begin
						tries_q   <= max_att_q;
						boff_on_q <= 1'b0;
						if (kind_q == KIND_INSTALLER) begin
							access_q <= 1'b1;
						end
						mode_q <= MODE_UNLOCKED;
						res_q  <= OUT_ACCEPTED;
					end else begin
						tries_q <= tries_dec;
						if (tries_dec == '0) begin
							boff_on_q    <= 1'b1;
							boff_until_q <= req_q.now_seconds + backoff_s_q;
							res_q        <= OUT_BACKOFF;
						end else begin
							res_q <= OUT_REJECTED;
						end
					end
				end
				default: ;
			endcase

			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// event latch and result register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= in_data;
		end
		if (emit_fire) begin
			out_q.outcome           <= res_q;
			out_q.screen_lock       <= mode_q;
			out_q.installer_granted <= access_q;
			out_q.tries_remaining   <= tries_q;
			out_q.digits_entered    <= count_q;
			out_q.in_backoff        <= boff_act;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ sv/plc_checker.sv @@
`timescale 1ns / 1ps

module plc_checker #(
	parameter int unsigned PIN_LEN = plc_pkg::PinLenDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_ready,
	input  logic          out_valid,
	input  logic          out_ready,
	input  plc_pkg::out_t out_data
);
	import plc_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// one event at a time
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after an input transfer");

	// a full PIN is always checked and wiped
	a_digit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.digits_entered < 4'(PIN_LEN))
		else $error("digit count reached PIN length");

	a_backoff_tries: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.in_backoff |-> out_data.tries_remaining == 8'd0)
		else $error("backoff with tries left");

	a_accept_unlocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.outcome == OUT_ACCEPTED)
		|-> out_data.screen_lock == MODE_UNLOCKED)
		else $error("accepted PIN left the screen locked");

endmodule

bind pin_entry_lock_controller plc_checker #(
	.PIN_LEN (PIN_LEN)
) u_plc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import plc_pkg::*;

	localparam int unsigned PinDigits = 4;
	// FNV-1a offset basis and prime, kept independent of the package copies
	localparam logic [31:0] HashStart = 32'd2166136261;
	localparam logic [31:0] HashMult  = 32'd16777619;

	typedef logic [4*PinDigits-1:0] pin_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	in_t      in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	out_t     out_data;
	logic     cfg_we = 1'b0;
	cfg_idx_t cfg_index = CFG_MAX_ATTEMPTS;
	logic [31:0] cfg_wdata = '0;

	pin_entry_lock_controller #(.PIN_LEN(PinDigits)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hard stop well beyond the slowest legal run (roughly 1 ms even with
	// every gap and stall at its longest).
	initial begin
		#6_000_000;
		$display("tb: failure");
		$finish;
	end

	// ---------------------------------------------------------------
	// Mirror of the register file, as the block should hold it
	// ---------------------------------------------------------------
	logic [7:0]  cfg_attempts = 8'd5;
	logic [31:0] cfg_backoff  = 32'd60;
	logic [31:0] cfg_relock   = 32'd300;
	logic [31:0] cfg_usalt    = '0;
	logic [31:0] cfg_uhash    = '0;
	logic [31:0] cfg_isalt    = '0;
	logic [31:0] cfg_ihash    = '0;
	logic [1:0]  cfg_pins     = '0;

	// ---------------------------------------------------------------
	// Lock state as predicted; reset values match the block's reset
	// ---------------------------------------------------------------
	mode_t       lock_st    = MODE_UNLOCKED;
	logic        lockout_st = 1'b0;
	logic        grant_st   = 1'b0;
	kind_t       kind_st    = KIND_NONE;
	pin_t        digits_st  = '0;
	logic [3:0]  count_st   = '0;
	logic [7:0]  tries_st   = 8'd5;
	logic        backoff_st = 1'b0;
	logic [31:0] backoff_end = '0;
	logic [31:0] last_touch = '0;

	// Event queue feeding the driver, and predicted status words awaiting
	// their transfer on the output side
	in_t  keypad_events[$];
	out_t predicted_status[$];
	int unsigned events_queued = 0;
	int unsigned events_taken  = 0;
	int unsigned results_seen  = 0;
	int unsigned mismatches    = 0;

	// Stimulus-side view of the PINs currently programmed and of the clock
	pin_t        user_pin = '0;
	pin_t        inst_pin = '0;
	logic [31:0] wall = 32'd100;

	// Salt bytes LSB first, then the digits in entry order
	function automatic logic [31:0] pin_fnv(logic [31:0] salt, pin_t pin);
		logic [31:0] h;
		h = HashStart;
		for (int i = 0; i < 4; i++)
			h = (h ^ {24'd0, salt[8*i +: 8]}) * HashMult;
		for (int i = 0; i < PinDigits; i++)
			h = (h ^ {28'd0, pin[4*i +: 4]}) * HashMult;
		return h;
	endfunction

	function automatic void clear_entry();
		kind_st   = KIND_NONE;
		count_st  = '0;
		digits_st = '0;
	endfunction

	// Applies one event to the predicted state, returns the status word
	function automatic out_t advance_lock(in_t ev);
		out_t        r;
		outcome_t    res;
		logic [31:0] now;
		logic [31:0] elapsed;
		logic        user_ok;
		logic        inst_ok;
		logic        ok;
		kind_t       was;
		now = ev.now_seconds;
		res = OUT_DONE;
		case (ev.cmd)
		CMD_DIGIT: begin
			last_touch = now;
			if (kind_st == KIND_NONE)
				res = OUT_IDLE;
			else if (backoff_st && now < backoff_end)
				res = OUT_BACKOFF;
			else if (ev.key_digit > 4'd9)
				res = OUT_PENDING;
			else begin
				if (count_st < PinDigits) begin
					digits_st[4*count_st +: 4] = ev.key_digit;
					count_st = count_st + 4'd1;
				end
				if (count_st < PinDigits)
					res = OUT_PENDING;
				else begin
					user_ok = cfg_pins[0] && (pin_fnv(cfg_usalt, digits_st) == cfg_uhash);
					inst_ok = cfg_pins[1] && (pin_fnv(cfg_isalt, digits_st) == cfg_ihash);
					was = kind_st;
					// installer entries and the installer lock take only the installer PIN
					if (was == KIND_INSTALLER || lock_st == MODE_INSTALLER)
						ok = inst_ok;
					else
						ok = user_ok || inst_ok;
					clear_entry();
					if (ok) begin
						tries_st   = cfg_attempts;
						backoff_st = 1'b0;
						if (was == KIND_INSTALLER)
							grant_st = 1'b1;
						lock_st = MODE_UNLOCKED;
						res     = OUT_ACCEPTED;
					end else begin
						if (tries_st > 8'd0)
							tries_st = tries_st - 8'd1;
						if (tries_st == 8'd0) begin
							backoff_st  = 1'b1;
							backoff_end = now + cfg_backoff;  // wraps mod 2^32
							res         = OUT_BACKOFF;
						end else
							res = OUT_REJECTED;
					end
				end
			end
		end
		CMD_BEGIN: begin
			clear_entry();
			kind_st    = ev.entry_purpose ? KIND_INSTALLER : KIND_SCREEN;
			last_touch = now;
		end
		CMD_CANCEL: clear_entry();
		CMD_TICK: begin
			if (backoff_st && now >= backoff_end) begin
				backoff_st = 1'b0;
				tries_st   = cfg_attempts;
			end
			// time running backwards counts as no time passed
			elapsed = (now >= last_touch) ? now - last_touch : 32'd0;
			if (elapsed >= cfg_relock) begin
				grant_st = 1'b0;
				clear_entry();
				if (lock_st == MODE_UNLOCKED) begin
					if (lockout_st)
						lock_st = MODE_INSTALLER;
					else if (cfg_pins[0])
						lock_st = MODE_USER;
				end
			end
		end
		CMD_LOCK_NOW: begin
			if (!cfg_pins[0] || lock_st == MODE_INSTALLER)
				res = OUT_REFUSED;
			else begin
				lock_st = MODE_USER;
				clear_entry();
				last_touch = now;
			end
		end
		CMD_LOCKOUT_ON: begin
			if (!cfg_pins[1])
				res = OUT_REFUSED;
			else begin
				lockout_st = 1'b1;
				lock_st    = MODE_INSTALLER;
				grant_st   = 1'b0;
				clear_entry();
				last_touch = now;
			end
		end
		CMD_LOCKOUT_OFF: begin
			lockout_st = 1'b0;
			if (lock_st == MODE_INSTALLER)
				lock_st = MODE_UNLOCKED;
			clear_entry();
			last_touch = now;
		end
		default: res = OUT_REFUSED;
		endcase
		r.outcome           = res;
		r.screen_lock       = lock_st;
		r.installer_granted = grant_st;
		r.tries_remaining   = tries_st;
		r.digits_entered    = count_st;
		r.in_backoff        = backoff_st && (now < backoff_end);
		return r;
	endfunction

	// Mostly no gap, sometimes a short one, now and then a long one
	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(string msg);
		$display("tb: mismatch at %0t ns, result %0d: %s", $time, results_seen, msg);
		mismatches++;
	endtask

	task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0d, should be %0d", name, got, want));
	endtask

	// ---------------------------------------------------------------
	// Driver: one event per transfer, random gaps between them, the
	// prediction taken at the edge of the transfer itself
	// ---------------------------------------------------------------
	int send_gap  = 0;
	int send_calm = 0;

	always @(posedge clk) begin
		logic busy;
		busy = in_valid;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predicted_status.push_back(advance_lock(in_data));
				events_taken++;
				busy = 1'b0;
			end
			if (!busy) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (keypad_events.size() > 0) begin
					in_valid <= 1'b1;
					in_data  <= keypad_events.pop_front();
					// occasional back-to-back stretch, otherwise a random gap
					if (send_calm > 0)
						send_calm--;
					else begin
						send_gap = idle_cycles();
						if ($urandom_range(0, 39) == 0)
							send_calm = $urandom_range(20, 60);
					end
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: checks each output transfer, stalls ready at random
	// ---------------------------------------------------------------
	int recv_stall = 0;
	int recv_calm  = 0;

	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (predicted_status.size() == 0)
					report_mismatch("status word with no event outstanding");
				else begin
					want = predicted_status.pop_front();
					compare_field("outcome", out_data.outcome, want.outcome);
					compare_field("screen_lock", out_data.screen_lock, want.screen_lock);
					compare_field("installer_granted", out_data.installer_granted,
						want.installer_granted);
					compare_field("tries_remaining", out_data.tries_remaining,
						want.tries_remaining);
					compare_field("digits_entered", out_data.digits_entered,
						want.digits_entered);
					compare_field("in_backoff", out_data.in_backoff, want.in_backoff);
				end
				results_seen++;
			end
			if (recv_stall > 0) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (recv_calm > 0)
					recv_calm--;
				else if ($urandom_range(0, 3) == 0) begin
					recv_stall = idle_cycles();
					if ($urandom_range(0, 9) == 0)
						recv_calm = $urandom_range(30, 90);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic logic [31:0] step_clock(logic [31:0] d);
		wall = wall + d;
		return wall;
	endfunction

	// Usually a small step; sometimes long silence, a step back or a jump
	function automatic logic [31:0] random_now();
		int r;
		r = $urandom_range(0, 99);
		if (r < 2)
			wall = wall - $urandom_range(1, 500);
		else if (r < 3)
			wall = $urandom;
		else if (r < 9)
			wall = wall + $urandom_range(50, 400);
		else
			wall = wall + $urandom_range(0, 3);
		return wall;
	endfunction

	function automatic pin_t random_pin();
		pin_t p;
		for (int i = 0; i < PinDigits; i++)
			p[4*i +: 4] = $urandom_range(0, 9);
		return p;
	endfunction

	task automatic queue_event(cmd_t c, logic [3:0] key, logic purpose, logic [31:0] now);
		in_t ev;
		ev.cmd           = c;
		ev.key_digit     = key;
		ev.entry_purpose = purpose;
		ev.now_seconds   = now;
		keypad_events.push_back(ev);
		events_queued++;
	endtask

	task automatic queue_entry(logic purpose, pin_t pin);
		queue_event(CMD_BEGIN, $urandom_range(0, 15), purpose, step_clock(1));
		for (int i = 0; i < PinDigits; i++)
			queue_event(CMD_DIGIT, pin[4*i +: 4], $urandom_range(0, 1), step_clock(1));
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
		CFG_MAX_ATTEMPTS:   cfg_attempts = (val[7:0] == 8'd0) ? 8'd1 : val[7:0];
		CFG_BACKOFF_SEC:    cfg_backoff  = val;
		CFG_RELOCK_SEC:     cfg_relock   = val;
		CFG_USER_SALT:      cfg_usalt    = val;
		CFG_USER_HASH:      cfg_uhash    = val;
		CFG_INSTALLER_SALT: cfg_isalt    = val;
		CFG_INSTALLER_HASH: cfg_ihash    = val;
		CFG_PINS_PRESENT:   cfg_pins     = val[1:0];
		default: ;
		endcase
	endtask

	// Fresh PINs each time; spoil_user stores a hash no PIN can match
	task automatic program_lock(logic [31:0] attempts, logic [31:0] backoff,
			logic [31:0] relock, logic [31:0] usalt, logic [31:0] isalt,
			logic [31:0] pins, logic spoil_user);
		logic [31:0] uh;
		user_pin = random_pin();
		inst_pin = random_pin();
		uh = pin_fnv(usalt, user_pin);
		if (spoil_user)
			uh = ~uh;
		write_reg(CFG_MAX_ATTEMPTS, attempts);
		write_reg(CFG_BACKOFF_SEC, backoff);
		write_reg(CFG_RELOCK_SEC, relock);
		write_reg(CFG_USER_SALT, usalt);
		write_reg(CFG_USER_HASH, uh);
		write_reg(CFG_INSTALLER_SALT, isalt);
		write_reg(CFG_INSTALLER_HASH, pin_fnv(isalt, inst_pin));
		write_reg(CFG_PINS_PRESENT, pins);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly complete entries with the right, the other or a wrong PIN,
	// salted with stray keys, cancels, ticks and lock commands
	task automatic random_traffic(int unsigned n);
		int unsigned stop_at;
		int          r;
		int          pick;
		pin_t        pin;
		stop_at = events_queued + n;
		while (events_queued < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				pick = $urandom_range(0, 9);
				pin = (pick < 4) ? user_pin : (pick < 7) ? inst_pin : random_pin();
				queue_event(CMD_BEGIN, $urandom_range(0, 15),
					$urandom_range(0, 9) < 3, random_now());
				for (int i = 0; i < PinDigits; i++) begin
					if ($urandom_range(0, 19) == 0)
						queue_event(CMD_DIGIT, $urandom_range(10, 15),
							$urandom_range(0, 1), random_now());
					if ($urandom_range(0, 39) == 0)
						queue_event(CMD_CANCEL, $urandom_range(0, 15),
							$urandom_range(0, 1), random_now());
					queue_event(CMD_DIGIT, pin[4*i +: 4], $urandom_range(0, 1),
						random_now());
				end
			end else if (r < 70)
				queue_event(CMD_TICK, $urandom_range(0, 15), $urandom_range(0, 1),
					random_now());
			else if (r < 82) begin
				pick = $urandom_range(0, 2);
				queue_event((pick == 0) ? CMD_LOCK_NOW :
					(pick == 1) ? CMD_LOCKOUT_ON : CMD_LOCKOUT_OFF,
					$urandom_range(0, 15), $urandom_range(0, 1), random_now());
			end else if (r < 92)
				queue_event(CMD_DIGIT, $urandom_range(0, 15), $urandom_range(0, 1),
					random_now());
			else
				queue_event(cmd_t'($urandom_range(0, 7)), $urandom_range(0, 15),
					$urandom_range(0, 1), $urandom);
		end
	endtask

	// Blocks until every event has gone through and every status word is back
	task automatic wait_drained();
		while (events_taken != events_queued || predicted_status.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------
	initial begin
		// Reset register values, no PINs: idle digit, unknown command,
		// refusals, a stray key, a miss with no PIN set, relock with no
		// user PIN and time running backwards
		queue_event(CMD_DIGIT, 4'd5, 1'b0, step_clock(1));
		queue_event(CMD_UNKNOWN, 4'd15, 1'b1, step_clock(1));
		queue_event(CMD_LOCK_NOW, 4'd0, 1'b0, step_clock(1));
		queue_event(CMD_LOCKOUT_ON, 4'd0, 1'b0, step_clock(1));
		queue_event(CMD_LOCKOUT_OFF, 4'd0, 1'b0, step_clock(1));
		queue_event(CMD_BEGIN, 4'd0, 1'b0, step_clock(1));
		queue_event(CMD_DIGIT, 4'd15, 1'b0, step_clock(1));
		queue_event(CMD_DIGIT, 4'd0, 1'b0, step_clock(1));
		queue_event(CMD_DIGIT, 4'd9, 1'b0, step_clock(1));
		queue_event(CMD_DIGIT, 4'd0, 1'b1, step_clock(1));
		queue_event(CMD_DIGIT, 4'd9, 1'b0, step_clock(1));
		queue_event(CMD_BEGIN, 4'd0, 1'b1, step_clock(1));
		queue_event(CMD_CANCEL, 4'd0, 1'b0, step_clock(1));
		queue_event(CMD_TICK, 4'd0, 1'b0, 32'hFFFF_FFFF);
		queue_event(CMD_TICK, 4'd0, 1'b0, 32'd0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		wait_drained();
		random_traffic(100);
		wait_drained();

		// One try only: accept, lock now, lockout, installer-only accept,
		// access grant, backoff, a digit with no entry open in backoff, backoff expiry,
		// lockout off and an inactivity relock
		program_lock(32'd1, 32'd60, 32'd300, $urandom, $urandom, 32'd3, 1'b0);
		wall = 32'd1000;
		queue_entry(1'b0, user_pin);
		queue_event(CMD_LOCK_NOW, 4'd0, 1'b0, step_clock(1));
		queue_event(CMD_LOCKOUT_ON, 4'd0, 1'b0, step_clock(1));
		queue_entry(1'b0, inst_pin);
		queue_entry(1'b1, inst_pin);
		queue_entry(1'b0, user_pin ^ pin_t'(1));
		queue_event(CMD_DIGIT, 4'd3, 1'b0, step_clock(1));
		queue_event(CMD_TICK, 4'd0, 1'b0, step_clock(61));
		queue_event(CMD_LOCKOUT_OFF, 4'd0, 1'b0, step_clock(1));
		queue_event(CMD_TICK, 4'd0, 1'b0, step_clock(400));
		random_traffic(150);
		wait_drained();

		// A write of 256 leaves zero in the low byte, stored as one try;
		// no backoff time and immediate relock; user PIN only
		program_lock(32'h100, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1, 1'b0);
		random_traffic(180);
		wait_drained();

		// Largest budget and times; backoff end wraps; installer PIN only
		program_lock(32'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,
			32'd2, 1'b0);
		wall = 32'hFFFF_FF00;
		random_traffic(180);
		wait_drained();

		// Zero budget (held as one), short times, user hash unmatchable
		program_lock(32'd0, 32'd20, 32'd40, $urandom, $urandom, 32'd3, 1'b1);
		random_traffic(180);
		wait_drained();

		program_lock(32'd3, $urandom_range(5, 30), 32'd100, $urandom, $urandom, 32'd3,
			1'b0);
		random_traffic(220);
		wait_drained();

		// No PINs stored: every entry misses
		program_lock($urandom_range(1, 8), $urandom_range(1, 50), $urandom_range(20, 200),
			$urandom, $urandom, 32'd0, 1'b0);
		random_traffic(120);
		wait_drained();

		// Watch for stray status words past the last transfer
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ pin_entry_lock_controller.f @@
sv/plc_pkg.sv
sv/plc_fnv.sv
sv/pin_entry_lock_controller.sv
sv/plc_checker.sv
test/testbench.sv
